@@ hdl/cdo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdo_pkg
// Shared types, constants and the month length table for the calendar
// day offset block.
// ----------------------------------------------------------------------------
package cdo_pkg;

  // Field widths of the command and result transfers.
  localparam int DayW   = 5;
  localparam int MonW   = 4;
  localparam int YearW  = 14;
  localparam int CountW = 16;

  // Internal working widths: the day accumulator spans -65535..65566 and
  // the working year stays within a few hundred years of 0..16383.
  localparam int DayAccW  = 18;
  localparam int YearAccW = 16;

  localparam logic [MonW-1:0]  MonthsPerYear = 4'd12;
  localparam logic [MonW-1:0]  FirstMonth    = 4'd1;
  localparam logic [YearW-1:0] YearMax       = 14'd9999;

  // Direction codes.
  localparam logic ActAdd = 1'b0;
  localparam logic ActSub = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Capture a new date and apply the day count.
    logic step_fwd;   // Consume the current month and move to the next.
    logic step_back;  // Borrow the previous month's days.
    logic finish;     // Saturate the year and register the result.
  } cdo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic day_gt_len;  // Day exceeds the length of the current month.
    logic day_lt_one;  // Day is below the first of the month.
  } cdo_stat_t;

  // Month length in a calendar without leap years; anything outside
  // 1..12 counts as a 31-day month.
  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ hdl/calendar_day_offset_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_day_offset_core
// Moves a date by a signed number of days in a calendar without leap years.
// ----------------------------------------------------------------------------
// A command transfer happens when start is high and busy is low. The block
// then walks the date one month per clock cycle through a single month
// step unit, crossing up to about 2200 months for a count of 65535. The
// result is shown for exactly one cycle with out_valid high; out_valid
// rises at the same clock edge at which busy falls. There is no
// backpressure, so the receiver must take it in that cycle. The result
// ports hold their value until the next result. A new command may be
// started in the cycle that out_valid is high.
module calendar_day_offset_core import cdo_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_action,
  input  logic [DayW-1:0]   in_day_in,
  input  logic [MonW-1:0]   in_month_in,
  input  logic [YearW-1:0]  in_year_in,
  input  logic [CountW-1:0] in_day_count,
  output logic              out_valid,
  output logic [DayW-1:0]   out_day_out,
  output logic [MonW-1:0]   out_month_out,
  output logic [YearW-1:0]  out_year_out,
  output logic              out_year_overflow
);

  cdo_cmd_t  cmd;
  cdo_stat_t stat;

  // Sequencer.
  cdo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Date registers and month step logic.
  cdo_dpath u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .action        (in_action),
    .day_in        (in_day_in),
    .month_in      (in_month_in),
    .year_in       (in_year_in),
    .day_count     (in_day_count),
    .stat          (stat),
    .day_out       (out_day_out),
    .month_out     (out_month_out),
    .year_out      (out_year_out),
    .year_overflow (out_year_overflow)
  );

endmodule

@@ hdl/cdo_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdo_dpath
// Date registers, one-month step logic and the saturating result stage.
// ----------------------------------------------------------------------------
module cdo_dpath import cdo_pkg::*; (
  input  logic                clk,
  input  cdo_cmd_t            cmd,
  input  logic                action,
  input  logic [DayW-1:0]     day_in,
  input  logic [MonW-1:0]     month_in,
  input  logic [YearW-1:0]    year_in,
  input  logic [CountW-1:0]   day_count,
  output cdo_stat_t           stat,
  output logic [DayW-1:0]     day_out,
  output logic [MonW-1:0]     month_out,
  output logic [YearW-1:0]    year_out,
  output logic                year_overflow
);

  logic signed [DayAccW-1:0]  day_r, day_nxt;
  logic [MonW-1:0]            mon_r, mon_nxt;
  logic signed [YearAccW-1:0] year_r, year_nxt;

  logic [DayW-1:0]            day_out_r;
  logic [MonW-1:0]            mon_out_r;
  logic [YearW-1:0]           year_out_r;
  logic                       ovf_r;

  logic [MonW-1:0]            mon_prev;
  logic [DayW-1:0]            len_cur, len_prev;
  logic signed [DayAccW-1:0]  len_cur_ext, len_prev_ext;
  logic [DayAccW-1:0]         day_ext, cnt_ext;
  logic signed [YearAccW-1:0] year_ext;

  // Month lengths for the current and the preceding month.
  assign mon_prev     = (mon_r == FirstMonth) ? MonthsPerYear : mon_r - 4'd1;
  assign len_cur      = month_len(mon_r);
  assign len_prev     = month_len(mon_prev);
  assign len_cur_ext  = $signed({{(DayAccW-DayW){1'b0}}, len_cur});
  assign len_prev_ext = $signed({{(DayAccW-DayW){1'b0}}, len_prev});

  assign day_ext  = {{(DayAccW-DayW){1'b0}}, day_in};
  assign cnt_ext  = {{(DayAccW-CountW){1'b0}}, day_count};
  assign year_ext = $signed({{(YearAccW-YearW){1'b0}}, year_in});

  // Status for the controller.
  assign stat.day_gt_len = (day_r > len_cur_ext);
  assign stat.day_lt_one = (day_r < $signed(18'sd1));

  // Next working date: load, or one month step in either direction.
  always_comb begin
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    priority if (cmd.load) begin
      day_nxt = (action == ActSub) ? $signed(day_ext - cnt_ext)
                                   : $signed(day_ext + cnt_ext);
      if (month_in == 4'd0) begin
        mon_nxt  = MonthsPerYear;
        year_nxt = year_ext - 16'sd1;
      end else if (month_in > MonthsPerYear) begin
        mon_nxt  = month_in - MonthsPerYear;
        year_nxt = year_ext + 16'sd1;
      end else begin
        mon_nxt  = month_in;
        year_nxt = year_ext;
      end
    end else if (cmd.step_fwd) begin
      day_nxt = day_r - len_cur_ext;
      if (mon_r == MonthsPerYear) begin
        mon_nxt  = FirstMonth;
        year_nxt = year_r + 16'sd1;
      end else begin
        mon_nxt = mon_r + 4'd1;
      end
    end else if (cmd.step_back) begin
      day_nxt = day_r + len_prev_ext;
      mon_nxt = mon_prev;
      if (mon_r == FirstMonth) begin
        year_nxt = year_r - 16'sd1;
      end
    end else begin
      // No command: the working date holds.
      day_nxt  = day_r;
      mon_nxt  = mon_r;
      year_nxt = year_r;
    end
  end

  always_ff @(posedge clk) begin
    day_r  <= day_nxt;
    mon_r  <= mon_nxt;
    year_r <= year_nxt;
  end

  // Result registers, with the year saturated to 0..9999.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      day_out_r <= day_r[DayW-1:0];
      mon_out_r <= mon_r;
      if (year_r < 16'sd0) begin
        year_out_r <= '0;
        ovf_r      <= 1'b1;
      end else if (year_r > $signed({2'b00, YearMax})) begin
        year_out_r <= YearMax;
        ovf_r      <= 1'b1;
      end else begin
        year_out_r <= year_r[YearW-1:0];
        ovf_r      <= 1'b0;
      end
    end
  end

  assign day_out       = day_out_r;
  assign month_out     = mon_out_r;
  assign year_out      = year_out_r;
  assign year_overflow = ovf_r;

endmodule

@@ hdl/cdo_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdo_ctrl
// Sequencer: loads a command, walks months forward, then backward, and
// strobes the result.
// ----------------------------------------------------------------------------
module cdo_ctrl import cdo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  cdo_stat_t stat,
  output cdo_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FWD  = 2'd1;
  localparam logic [1:0] S_BACK = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_FWD;
        end
      end
      S_FWD: begin
        if (stat.day_gt_len) begin
          cmd.step_fwd = 1'b1;
        end else begin
          state_nxt = S_BACK;
        end
      end
      S_BACK: begin
        if (stat.day_lt_one) begin
          cmd.step_back = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          valid_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

@@ hdl/cdo_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdo_checker
// Port-level checks for the calendar day offset block.
// ----------------------------------------------------------------------------
module cdo_checker import cdo_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [DayW-1:0]   out_day_out,
  input logic [MonW-1:0]   out_month_out,
  input logic [YearW-1:0]  out_year_out,
  input logic              out_year_overflow
);

  // An accepted command keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a command transfer");

  // A result strobe lasts one cycle and comes only while idle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result strobe while busy or longer than one cycle");

  // A result carries a valid month and a day within it.
  a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_out >= 4'd1 && out_month_out <= 4'd12 &&
                   out_day_out >= 5'd1 && out_day_out <= month_len(out_month_out)))
    else $error("result date out of range");

  // The year is in range, and a flagged year sits at a limit.
  a_year_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year_out <= YearMax &&
                   (!out_year_overflow || out_year_out == 14'd0 ||
                    out_year_out == YearMax)))
    else $error("result year not saturated correctly");

endmodule

bind calendar_day_offset_core cdo_checker u_cdo_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_day_out       (out_day_out),
  .out_month_out     (out_month_out),
  .out_year_out      (out_year_out),
  .out_year_overflow (out_year_overflow)
);

@@ tb/sv/tb_calendar_day_offset_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_day_offset_core
// Self-checking testbench for the calendar day offset core. It sends dated
// offset commands and predicts each shifted date in the no-leap calendar.
// Every result is then compared field by field in the order sent.
// ----------------------------------------------------------------------------
module tb_calendar_day_offset_core import cdo_pkg::*; ();

  localparam int FebDays        = 28;
  localparam int ShortMonthDays = 30;
  localparam int LongMonthDays  = 31;
  localparam int DrainCycles    = 10;

  // One offset command as it crosses the input ports.
  typedef struct packed {
    logic              action;
    logic [DayW-1:0]   day;
    logic [MonW-1:0]   mon;
    logic [YearW-1:0]  year;
    logic [CountW-1:0] count;
  } date_cmd_t;

  // One shifted date as it appears on the result ports.
  typedef struct packed {
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  mon;
    logic [YearW-1:0] year;
    logic             ovf;
  } moved_date_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_action;
  logic [DayW-1:0]   in_day_in;
  logic [MonW-1:0]   in_month_in;
  logic [YearW-1:0]  in_year_in;
  logic [CountW-1:0] in_day_count;
  logic              out_valid;
  logic [DayW-1:0]   out_day_out;
  logic [MonW-1:0]   out_month_out;
  logic [YearW-1:0]  out_year_out;
  logic              out_year_overflow;

  moved_date_t expected_dates[$];
  int          mismatch_count = 0;

  calendar_day_offset_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_day_in         (in_day_in),
    .in_month_in       (in_month_in),
    .in_year_in        (in_year_in),
    .in_day_count      (in_day_count),
    .out_valid         (out_valid),
    .out_day_out       (out_day_out),
    .out_month_out     (out_month_out),
    .out_year_out      (out_year_out),
    .out_year_overflow (out_year_overflow)
  );

  // Free-running clock with a 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Month length in a calendar without leap years; out-of-range months count
  // as long months.
  function automatic int days_of_month(input int m);
    int len;
    case (m)
      2:             len = FebDays;
      4, 6, 9, 11:   len = ShortMonthDays;
      default:       len = LongMonthDays;
    endcase
    return len;
  endfunction

  // Shifts the date by the signed day count and normalizes it month by month.
  function automatic moved_date_t predict_moved_date(input date_cmd_t c);
    int          d;
    int          m;
    int          y;
    moved_date_t r;
    d = int'(c.day);
    m = int'(c.mon);
    y = int'(c.year);
    // Month zero belongs to the year before, months past twelve to the next.
    if (m == 0) begin
      m = MonthsPerYear;
      y = y - 1;
    end else if (m > MonthsPerYear) begin
      m = m - MonthsPerYear;
      y = y + 1;
    end
    if (c.action == ActSub) begin
      d = d - int'(c.count);
    end else begin
      d = d + int'(c.count);
    end
    // Walk forward while the day spills past the current month.
    while (d > days_of_month(m)) begin
      d = d - days_of_month(m);
      m = m + 1;
      if (m > MonthsPerYear) begin
        m = FirstMonth;
        y = y + 1;
      end
    end
    // Borrow from preceding months while the day is below the first.
    while (d < 1) begin
      m = m - 1;
      if (m < 1) begin
        m = MonthsPerYear;
        y = y - 1;
      end
      d = d + days_of_month(m);
    end
    r.ovf = 1'b0;
    if (y < 0) begin
      y = 0;
      r.ovf = 1'b1;
    end else if (y > int'(YearMax)) begin
      y = YearMax;
      r.ovf = 1'b1;
    end
    r.day  = d[DayW-1:0];
    r.mon  = m[MonW-1:0];
    r.year = y[YearW-1:0];
    return r;
  endfunction

  function automatic date_cmd_t make_cmd(input logic act, input int d, input int m,
                                         input int y, input int cnt);
    date_cmd_t c;
    c.action = act;
    c.day    = d[DayW-1:0];
    c.mon    = m[MonW-1:0];
    c.year   = y[YearW-1:0];
    c.count  = cnt[CountW-1:0];
    return c;
  endfunction

  // Random command: mostly valid dates and short counts, with the full field
  // ranges and the longest counts mixed in.
  function automatic date_cmd_t random_date_cmd();
    date_cmd_t c;
    int        pick;
    c.action = 1'($urandom_range(0, 1));
    c.day    = DayW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(1, 31));
    c.mon    = MonW'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 12));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      c.year = YearW'($urandom_range(0, 16383));
    end else if (pick == 1) begin
      c.year = YearW'($urandom_range(0, 3));
    end else if (pick == 2) begin
      c.year = YearW'($urandom_range(9996, 9999));
    end else begin
      c.year = YearW'($urandom_range(0, 9999));
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      c.count = CountW'($urandom_range(0, 400));
    end else if (pick < 93) begin
      c.count = CountW'($urandom_range(0, 5000));
    end else if (pick < 97) begin
      c.count = CountW'($urandom_range(0, 65535));
    end else begin
      c.count = CountW'($urandom_range(65000, 65535));
    end
    return c;
  endfunction

  // Keeps start low for a number of cycles and puts noise on the fields.
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start        = 1'b0;
      in_action    = 1'($urandom_range(0, 1));
      in_day_in    = DayW'($urandom);
      in_month_in  = MonW'($urandom);
      in_year_in   = YearW'($urandom);
      in_day_count = CountW'($urandom);
    end
  endtask

  // Presents one command and waits for its transfer. Busy only changes on a
  // rising edge, so its value at the falling edge decides the next edge.
  task automatic send_date_cmd(input date_cmd_t c);
    @(negedge clk);
    start        = 1'b1;
    in_action    = c.action;
    in_day_in    = c.day;
    in_month_in  = c.mon;
    in_year_in   = c.year;
    in_day_count = c.count;
    while (busy) begin
      @(negedge clk);
    end
    @(posedge clk);
    expected_dates.push_back(predict_moved_date(c));
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
               act_val);
    end
  endtask

  // Each result transfer is compared with the oldest pending date.
  always @(posedge clk) begin
    moved_date_t exp_date;
    if (rst_n && out_valid) begin
      if (expected_dates.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, expected none, actual %0d-%0d-%0d ovf %0d",
                 $time, out_year_out, out_month_out, out_day_out, out_year_overflow);
      end else begin
        exp_date = expected_dates.pop_front();
        check_field("day_out", exp_date.day, out_day_out);
        check_field("month_out", exp_date.mon, out_month_out);
        check_field("year_out", exp_date.year, out_year_out);
        check_field("year_overflow", exp_date.ovf, out_year_overflow);
      end
    end
  end

  // Smallest and largest values of every field, in both directions.
  task automatic test_field_extremes();
    send_date_cmd(make_cmd(ActAdd, 1, 1, 0, 0));
    send_date_cmd(make_cmd(ActAdd, 31, 12, 9999, 0));
    send_date_cmd(make_cmd(ActAdd, 31, 12, 9999, 1));
    send_date_cmd(make_cmd(ActSub, 1, 1, 0, 1));
    send_date_cmd(make_cmd(ActAdd, 1, 1, 16383, 65535));
    send_date_cmd(make_cmd(ActSub, 31, 15, 0, 65535));
    send_date_cmd(make_cmd(ActAdd, 31, 15, 16383, 65535));
    send_date_cmd(make_cmd(ActSub, 0, 0, 0, 65535));
    hold_off($urandom_range(1, 6));
  endtask

  // Month zero and months past twelve move into the neighboring year.
  task automatic test_month_wrap();
    send_date_cmd(make_cmd(ActAdd, 15, 0, 2000, 0));
    send_date_cmd(make_cmd(ActSub, 10, 0, 0, 0));
    send_date_cmd(make_cmd(ActAdd, 5, 13, 500, 0));
    send_date_cmd(make_cmd(ActSub, 20, 14, 9998, 3));
    send_date_cmd(make_cmd(ActAdd, 31, 15, 9999, 0));
    hold_off($urandom_range(1, 6));
  endtask

  // Days past the month length spill forward; day zero borrows backward.
  task automatic test_day_normalize();
    send_date_cmd(make_cmd(ActAdd, 31, 2, 1999, 0));
    send_date_cmd(make_cmd(ActAdd, 31, 4, 1999, 0));
    send_date_cmd(make_cmd(ActAdd, 0, 3, 2001, 0));
    send_date_cmd(make_cmd(ActSub, 0, 1, 100, 0));
    send_date_cmd(make_cmd(ActSub, 5, 3, 2024, 5));
    send_date_cmd(make_cmd(ActAdd, 28, 2, 2024, 1));
    send_date_cmd(make_cmd(ActAdd, 31, 12, 1, 365));
    hold_off($urandom_range(1, 6));
  endtask

  // Start years above 9999 and results below zero saturate.
  task automatic test_year_saturation();
    send_date_cmd(make_cmd(ActAdd, 1, 6, 10000, 0));
    send_date_cmd(make_cmd(ActSub, 1, 6, 16383, 65535));
    send_date_cmd(make_cmd(ActSub, 1, 1, 1, 366));
    send_date_cmd(make_cmd(ActAdd, 2, 1, 9999, 364));
    hold_off($urandom_range(1, 6));
  endtask

  // Random commands in bursts of random length with random gaps; some gaps
  // start once the block has gone idle so they overlap the result cycle.
  task automatic test_random_dates(input int num_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < num_items) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        send_date_cmd(random_date_cmd());
        sent++;
      end
      case ($urandom_range(0, 3))
        0: ;
        1: hold_off($urandom_range(1, 3));
        2: hold_off($urandom_range(1, 12));
        default: begin
          hold_off(1);
          while (busy) begin
            @(negedge clk);
          end
          hold_off($urandom_range(0, 4));
        end
      endcase
    end
  endtask

  // Main sequence: reset, directed tests, random traffic, then drain.
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = ActAdd;
    in_day_in    = '0;
    in_month_in  = '0;
    in_year_in   = '0;
    in_day_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    hold_off(2);

    test_field_extremes();
    test_month_wrap();
    test_day_normalize();
    test_year_saturation();
    test_random_dates(250);

    hold_off(1);
    while (expected_dates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("calendar_day_offset_core regression: pass");
    end else begin
      $display("calendar_day_offset_core regression: fail");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run of the whole sequence.
  initial begin
    #30_000_000;
    $display("calendar_day_offset_core regression: fail");
    $finish;
  end

endmodule
